@@ rtl/lphm_pkg.sv @@
// Package for the linear probe hash map: payload structs, status and command
// codes, hash constants and sizing defaults. No dependencies.
`timescale 1ns / 1ps

package lphm_pkg;

  localparam int unsigned SLOTS_DEFAULT = 1024;
  localparam int unsigned CNT_W         = 11;
  localparam int unsigned LIMIT_W       = 10;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam logic [LIMIT_W-1:0] FILL_LIMIT_RESET = 10'd768;

  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
  localparam int unsigned MIX_S1 = 30;
  localparam int unsigned MIX_S2 = 27;
  localparam int unsigned MIX_S3 = 31;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_NEW  = 3'd0,
    ST_OVER = 3'd1,
    ST_HIT  = 3'd2,
    ST_MISS = 3'd3,
    ST_ZERO = 3'd4,
    ST_FULL = 3'd5
  } status_e;

  typedef struct packed {
    cmd_e               cmd;
    logic signed [63:0] key;
    logic signed [63:0] value;
  } item_t;

  typedef struct packed {
    status_e            status;
    logic signed [63:0] found_value;
  } result_t;

  typedef struct packed {
    item_t item;
    logic  zero;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL1,
    F_MUL2,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_CLR,
    B_IDLE,
    B_RD,
    B_CMP
  } back_state_e;

endpackage

@@ rtl/linear_probe_hash_map_unit.sv @@
// Top level of the linear probe hash map: fill limit register, front end,
// queue and back end. Uses lphm_pkg, lphm_front, lphm_queue and lphm_back.
//
// Usage: drive item_i and raise start; the command transfers at a clock edge
// where start is high and busy is low. Each command gives exactly one result
// on result_o, marked by res_valid_o for one cycle; results come back in
// command order and the receiver cannot hold them off.
// Flow: the front end hashes each nonzero key with two 64-bit multiplies
// (each three passes through one 32x32 multiplier); a zero key skips the
// hash. The back end then picks up the command and, for each slot visited
// on the probe path, does a registered memory read, then a compare. A new
// command is taken once the front end has pushed the last one, while the queue
// has room; the back end sets the pace when probe paths run longer than 3 slots.
// Reset: a clearing pass writes every key slot to empty, with busy high
// throughout; fill_limit returns to 768 and the live count to zero.
// cfg_we_i writes fill_limit; write it only while no command is in flight.
`timescale 1ns / 1ps

module linear_probe_hash_map_unit #(
  parameter int unsigned SLOTS = lphm_pkg::SLOTS_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  lphm_pkg::item_t              item_i,
  output logic                         res_valid_o,
  output lphm_pkg::result_t            result_o,
  input  logic                         cfg_we_i,
  input  logic [lphm_pkg::LIMIT_W-1:0] cfg_wdata_i
);
  import lphm_pkg::*;

  localparam int unsigned SlotW = $clog2(SLOTS);
  localparam int unsigned QW    = $bits(job_t) + SlotW;

  logic [LIMIT_W-1:0] fill_limit_q;
  logic               accept;
  logic               front_busy;
  logic               clearing;
  logic               q_full, q_empty, push, pop;
  job_t               push_job, pop_job;
  logic [SlotW-1:0]   push_slot, pop_slot;
  logic [QW-1:0]      pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_limit_q <= FILL_LIMIT_RESET;
    end else if (cfg_we_i) begin
      fill_limit_q <= cfg_wdata_i;
    end
  end

  assign busy   = front_busy || clearing;
  assign accept = start && !busy;

  lphm_front #(.SLOTS(SLOTS)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item_i),
    .busy_o   (front_busy),
    .q_full_i (q_full),
    .push_o   (push),
    .job_o    (push_job),
    .slot_o   (push_slot)
  );

  lphm_queue #(.Width(QW), .Depth(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({push_job, push_slot}),
    .full_o  (q_full),
    .pop_i   (pop),
    .data_o  (pop_data),
    .empty_o (q_empty)
  );

  assign pop_job  = pop_data[QW-1:SlotW];
  assign pop_slot = pop_data[SlotW-1:0];

  lphm_back #(.SLOTS(SLOTS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_job_i      (pop_job),
    .q_slot_i     (pop_slot),
    .pop_o        (pop),
    .fill_limit_i (fill_limit_q),
    .clearing_o   (clearing),
    .res_valid_o  (res_valid_o),
    .res_o        (result_o)
  );

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> busy)
    else $error("command port open during clearing pass");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("front end idle after a transfer");

  a_value_only_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && result_o.status != ST_HIT) |-> (result_o.found_value == '0))
    else $error("nonzero value on a result other than a hit");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("queue popped while empty");

endmodule

@@ rtl/lphm_front.sv @@
// Front end of the linear probe hash map: takes one command, flags zero keys
// and computes the home slot on one shared 32x32 multiplier. Uses lphm_pkg.
`timescale 1ns / 1ps

module lphm_front #(
  parameter int unsigned SLOTS = lphm_pkg::SLOTS_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  lphm_pkg::item_t          item_i,
  output logic                     busy_o,
  input  logic                     q_full_i,
  output logic                     push_o,
  output lphm_pkg::job_t           job_o,
  output logic [$clog2(SLOTS)-1:0] slot_o
);
  import lphm_pkg::*;

  localparam int unsigned SlotW = $clog2(SLOTS);

  front_state_e     state_q, state_d;
  logic [1:0]       step_q, step_d;
  logic [63:0]      x_q, x_d;
  logic [63:0]      acc_q, acc_d;
  job_t             job_q, job_d;
  logic [SlotW-1:0] slot_q, slot_d;

  logic [63:0] mul_b;
  logic [31:0] op_a, op_b;
  logic [63:0] prod;
  logic [63:0] sum;
  logic [63:0] key_u;

  assign key_u = $unsigned(item_i.key);
  assign mul_b = (state_q == F_MUL1) ? MIX_C1 : MIX_C2;

  always_comb begin
    case (step_q)
      2'd0: begin
        op_a = x_q[31:0];
        op_b = mul_b[31:0];
      end
      2'd1: begin
        op_a = x_q[63:32];
        op_b = mul_b[31:0];
      end
      default: begin
        op_a = x_q[31:0];
        op_b = mul_b[63:32];
      end
    endcase
  end

  assign prod = {32'h0, op_a} * {32'h0, op_b};
  assign sum  = (step_q == 2'd0) ? prod : acc_q + {prod[31:0], 32'h0};

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    x_d     = x_q;
    acc_d   = acc_q;
    job_d   = job_q;
    slot_d  = slot_q;
    push_o  = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (accept_i) begin
          job_d.item = item_i;
          job_d.zero = (key_u == 64'h0);
          x_d        = key_u ^ (key_u >> MIX_S1);
          step_d     = 2'd0;
          slot_d     = '0;
          state_d    = (key_u == 64'h0) ? F_PUSH : F_MUL1;
        end
      end
      F_MUL1: begin
        acc_d  = sum;
        step_d = step_q + 2'd1;
        if (step_q == 2'd2) begin
          x_d     = sum ^ (sum >> MIX_S2);
          step_d  = 2'd0;
          state_d = F_MUL2;
        end
      end
      F_MUL2: begin
        acc_d  = sum;
        step_d = step_q + 2'd1;
        if (step_q == 2'd2) begin
          x_d     = sum ^ (sum >> MIX_S3);
          slot_d  = x_d[SlotW-1:0];
          step_d  = 2'd0;
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    acc_q  <= acc_d;
    job_q  <= job_d;
    slot_q <= slot_d;
  end

  assign busy_o = (state_q != F_IDLE);
  assign job_o  = job_q;
  assign slot_o = slot_q;

endmodule

@@ rtl/lphm_queue.sv @@
// Small register queue between the hash front end and the probe back end.
// Generic width and depth; no package dependencies.
`timescale 1ns / 1ps

module lphm_queue #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_q];
  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);

endmodule

@@ rtl/lphm_back.sv @@
// Back end of the linear probe hash map: key and value memories, clearing
// pass, linear probe sequencer, live count and result register. Uses lphm_pkg.
`timescale 1ns / 1ps

module lphm_back #(
  parameter int unsigned SLOTS = lphm_pkg::SLOTS_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_empty_i,
  input  lphm_pkg::job_t                    q_job_i,
  input  logic [$clog2(SLOTS)-1:0]          q_slot_i,
  output logic                              pop_o,
  input  logic [lphm_pkg::LIMIT_W-1:0]      fill_limit_i,
  output logic                              clearing_o,
  output logic                              res_valid_o,
  output lphm_pkg::result_t                 res_o
);
  import lphm_pkg::*;

  localparam int unsigned SlotW = $clog2(SLOTS);
  localparam int unsigned CmpW  = (SlotW > CNT_W) ? SlotW : CNT_W;

  logic [63:0] key_mem [SLOTS];
  logic [63:0] val_mem [SLOTS];
  logic [63:0] key_rd_q, val_rd_q;

  back_state_e      state_q, state_d;
  job_t             job_q, job_d;
  logic [SlotW-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] live_q, live_d;
  logic             res_valid_q, res_valid_d;
  result_t          res_q, res_d;

  logic             key_we, val_we;
  logic [63:0]      key_wdata;
  logic [CmpW-1:0]  lim_ext, live_ext;
  logic             full;
  logic [63:0]      job_key;

  assign job_key  = $unsigned(job_q.item.key);
  assign live_ext = CmpW'(live_q);
  assign lim_ext  = (CmpW'(fill_limit_i) > CmpW'(SLOTS - 1)) ? CmpW'(SLOTS - 1)
                                                             : CmpW'(fill_limit_i);
  assign full     = (live_ext >= lim_ext);

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    ptr_d       = ptr_q;
    live_d      = live_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    pop_o       = 1'b0;
    key_we      = 1'b0;
    val_we      = 1'b0;
    key_wdata   = job_key;
    case (state_q)
      B_CLR: begin
        key_we    = 1'b1;
        key_wdata = 64'h0;
        ptr_d     = ptr_q + 1'b1;
        if (ptr_q == SlotW'(SLOTS - 1)) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          job_d = q_job_i;
          ptr_d = q_slot_i;
          if (q_job_i.zero) begin
            res_valid_d       = 1'b1;
            res_d.status      = ST_ZERO;
            res_d.found_value = '0;
          end else begin
            state_d = B_RD;
          end
        end
      end
      B_RD: begin
        state_d = B_CMP;
      end
      B_CMP: begin
        res_d.found_value = '0;
        if (key_rd_q == job_key) begin
          res_valid_d = 1'b1;
          state_d     = B_IDLE;
          if (job_q.item.cmd == CMD_LOOKUP) begin
            res_d.status      = ST_HIT;
            res_d.found_value = $signed(val_rd_q);
          end else begin
            val_we       = 1'b1;
            res_d.status = ST_OVER;
          end
        end else if (key_rd_q == 64'h0) begin
          res_valid_d = 1'b1;
          state_d     = B_IDLE;
          if (job_q.item.cmd == CMD_LOOKUP) begin
            res_d.status = ST_MISS;
          end else if (full) begin
            res_d.status = ST_FULL;
          end else begin
            key_we       = 1'b1;
            val_we       = 1'b1;
            live_d       = live_q + 1'b1;
            res_d.status = ST_NEW;
          end
        end else begin
          ptr_d   = ptr_q + 1'b1;
          state_d = B_RD;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLR;
      ptr_q       <= '0;
      live_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      live_q      <= live_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[ptr_q] <= key_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[ptr_q] <= $unsigned(job_q.item.value);
    end
  end

  always_ff @(posedge clk_i) begin
    key_rd_q <= key_mem[ptr_q];
    val_rd_q <= val_mem[ptr_q];
  end

  assign clearing_o  = (state_q == B_CLR);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
